@@ rtl/rqp_pkg.sv @@
`timescale 1ns / 1ps

package rqp_pkg;

  // Number of cells in the queue. The entry_count field is five bits wide,
  // so the depth stays at or below 31 without widening the result word.
  localparam int QueueDepth = 16;
  localparam int CountW     = 5;
  localparam int FieldW     = 10;

  typedef enum logic [1:0] {
    FUNC_ENQ   = 2'd0,
    FUNC_DEQ   = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef struct packed {
    func_e             func;
    logic [FieldW-1:0] requester_id;
    logic [FieldW-1:0] target_id;
    logic [FieldW-1:0] requester_followers;
    logic [FieldW-1:0] target_followers;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [FieldW-1:0] out_requester_id;
    logic [FieldW-1:0] out_target_id;
    logic [FieldW-1:0] out_requester_followers;
    logic [FieldW-1:0] out_target_followers;
    logic              found;
    logic [CountW-1:0] entry_count;
  } result_t;

  // One queue entry as held in a cell.
  typedef struct packed {
    logic [FieldW-1:0] requester;
    logic [FieldW-1:0] target;
    logic [FieldW-1:0] key;
    logic [FieldW-1:0] target_count;
  } entry_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

@@ rtl/request_priority_queue.sv @@
`timescale 1ns / 1ps

// Sorted priority queue of follow requests, built as a row of cells.
// A command word is taken on cmd_i at a rising edge where start is high and
// busy is low. busy stays low: every cell compares against the new word at
// once and moves in the same edge, so a command is taken every cycle.
// Commands: enqueue, dequeue of the head, and query for a requester id.
// One result word follows each command on result_o in the cycle right after
// acceptance, marked by done_o for exactly one cycle; throughput is one word
// per cycle. The receiver cannot stall, so a result that is not taken in its
// cycle is gone.
// Cell 0 holds the head, the largest key. An enqueue places the new entry in
// front of every entry whose key is less than or equal to its own; a full
// queue drops it with status full. A dequeue shifts every cell one place
// toward the head; on an empty queue it reports status empty.
// Reset (rst_ni low, asynchronous) empties the queue and clears done_o; the
// cell contents are left as they are, since an entry is only read once the
// entry count covers it.

module request_priority_queue import rqp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd_i,
  output logic    done_o,
  output result_t result_o
);

  logic [CountW-1:0] count_d, count_q;
  logic              done_d, done_q;
  result_t           res_d, res_q;

  entry_t     new_entry;
  entry_t     cell_entry [QueueDepth];
  logic       cell_gt    [QueueDepth];
  logic       cell_hit   [QueueDepth];
  logic       cell_valid [QueueDepth];
  cell_ctrl_t ctrl;

  logic accept;
  logic full;
  logic empty;
  logic any_hit;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CountW'(QueueDepth));
  assign empty  = (count_q == '0);

  assign new_entry.requester    = cmd_i.requester_id;
  assign new_entry.target       = cmd_i.target_id;
  assign new_entry.key          = cmd_i.requester_followers;
  assign new_entry.target_count = cmd_i.target_followers;

  // Rejected commands never reach the cells.
  assign ctrl.enq = accept && (cmd_i.func == FUNC_ENQ) && !full;
  assign ctrl.deq = accept && (cmd_i.func == FUNC_DEQ) && !empty;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    entry_t left_entry;
    entry_t right_entry;
    logic   left_gt;

    assign cell_valid[i] = (CountW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_gt    = 1'b1;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == QueueDepth - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    rqp_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .valid_i    (cell_valid[i]),
      .new_i      (new_entry),
      .left_i     (left_entry),
      .right_i    (right_entry),
      .left_gt_i  (left_gt),
      .query_id_i (cmd_i.requester_id),
      .entry_o    (cell_entry[i]),
      .gt_o       (cell_gt[i]),
      .hit_o      (cell_hit[i])
    );
  end

  always_comb begin
    any_hit = 1'b0;
    for (int i = 0; i < QueueDepth; i++) begin
      any_hit = any_hit | cell_hit[i];
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.enq) begin
      count_d = count_q + CountW'(1);
    end else if (ctrl.deq) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_comb begin
    res_d             = '0;
    res_d.status      = ST_OK;
    res_d.entry_count = count_d;
    case (cmd_i.func)
      FUNC_ENQ: begin
        if (full) begin
          res_d.status = ST_FULL;
        end
      end
      FUNC_DEQ: begin
        if (empty) begin
          res_d.status = ST_EMPTY;
        end else begin
          res_d.out_requester_id        = cell_entry[0].requester;
          res_d.out_target_id           = cell_entry[0].target;
          res_d.out_requester_followers = cell_entry[0].key;
          res_d.out_target_followers    = cell_entry[0].target_count;
        end
      end
      FUNC_QUERY: begin
        res_d.found = any_hit;
      end
      default: begin
        res_d.status = ST_OK;
      end
    endcase
  end

  assign done_d = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

@@ rtl/rqp_cell.sv @@
`timescale 1ns / 1ps

module rqp_cell import rqp_pkg::*; (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic              valid_i,
  input  entry_t            new_i,
  input  entry_t            left_i,
  input  entry_t            right_i,
  input  logic              left_gt_i,
  input  logic [FieldW-1:0] query_id_i,
  output entry_t            entry_o,
  output logic              gt_o,
  output logic              hit_o
);

  entry_t entry_d, entry_q;

  // The stored entry outranks the new one only when its key is strictly
  // larger, so a new entry lands ahead of all equal keys.
  assign gt_o    = valid_i && (new_i.key < entry_q.key);
  assign hit_o   = valid_i && (entry_q.requester == query_id_i);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.enq) begin
      if (gt_o) begin
        entry_d = entry_q;
      end else if (left_gt_i) begin
        entry_d = new_i;
      end else begin
        entry_d = left_i;
      end
    end else if (ctrl_i.deq) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ rtl/rqp_checker.sv @@
`timescale 1ns / 1ps

module rqp_checker import rqp_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input logic    done_o,
  input result_t result_o
);

  // Each accepted command gives exactly one result word, in the next cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("accepted command gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result word without a command");

  // A dropped enqueue only happens on a full queue.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_FULL) |->
      (result_o.entry_count == CountW'(QueueDepth)))
    else $error("full status with room left");

  // A failed dequeue reports no entry and an empty queue.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_EMPTY) |->
      (result_o.entry_count == '0 && result_o.out_requester_id == '0 &&
       result_o.out_requester_followers == '0))
    else $error("empty status with data or entries");

  // A query hit needs at least one queued entry.
  a_found_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.found) |-> (result_o.entry_count != '0))
    else $error("query hit on an empty queue");

endmodule

bind request_priority_queue rqp_checker u_rqp_checker (.*);
